FILE: rtl/ptzenc_pkg.sv
package ptzenc_pkg;

   localparam int FRAME_LEN = 7;
   localparam int IDX_W     = $clog2(FRAME_LEN);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

   // Byte positions within a frame.
   localparam logic [IDX_W-1:0] POS_SYNC     = IDX_W'(0);
   localparam logic [IDX_W-1:0] POS_ID       = IDX_W'(1);
   localparam logic [IDX_W-1:0] POS_FUNCTION = IDX_W'(2);
   localparam logic [IDX_W-1:0] POS_LENS     = IDX_W'(3);
   localparam logic [IDX_W-1:0] POS_MOTION   = IDX_W'(4);
   localparam logic [IDX_W-1:0] POS_END      = IDX_W'(5);

   // Fixed frame bytes and defaults.
   localparam logic [7:0] BYTE_SYNC       = 8'hA5;
   localparam logic [7:0] BYTE_END        = 8'h55;
   localparam logic [7:0] FN_DEFAULT      = 8'h10;
   localparam logic [7:0] LENS_DEFAULT    = 8'h0D;
   localparam logic [7:0] MOT_DEFAULT     = 8'h88;
   localparam logic [7:0] MOT_CENTRE_HIGH = 8'h80;
   localparam logic [7:0] MOT_CENTRE_LOW  = 8'h08;
   localparam logic [7:0] FN_PRESET_GO    = 8'h11;
   localparam logic [7:0] FN_PRESET_MODE1 = 8'h25;
   localparam logic [7:0] FN_PRESET_MODE2 = 8'h26;
   localparam logic [7:0] FN_HOME         = 8'h1D;
   localparam logic [7:0] FN_CFG_ON       = 8'h19;
   localparam logic [7:0] FN_CFG_OFF      = 8'h1F;
   localparam logic [7:0] FN_CFG_SET1     = 8'h13;
   localparam logic [7:0] BYTE_FIXED      = 8'h80;
   localparam logic [7:0] MOT_CFG_SET1    = 8'h81;
   localparam logic [7:0] LENS_FOCUS_NEAR = 8'h03;
   localparam logic [7:0] LENS_FOCUS_FAR  = 8'h04;
   localparam logic [7:0] LENS_IRIS_OPEN  = 8'h06;
   localparam logic [7:0] LENS_IRIS_CLOSE = 8'h05;
   localparam logic [7:0] LENS_ZOOM_IN    = 8'h0E;
   localparam logic [7:0] LENS_ZOOM_OUT   = 8'h0C;

   // Command kinds.
   localparam logic [4:0] KIND_CONFIG     = 5'd0;
   localparam logic [4:0] KIND_PAN_LEFT   = 5'd1;
   localparam logic [4:0] KIND_PAN_RIGHT  = 5'd2;
   localparam logic [4:0] KIND_TILT_UP    = 5'd3;
   localparam logic [4:0] KIND_TILT_DOWN  = 5'd4;
   localparam logic [4:0] KIND_LEFT_UP    = 5'd5;
   localparam logic [4:0] KIND_LEFT_DOWN  = 5'd6;
   localparam logic [4:0] KIND_RIGHT_UP   = 5'd7;
   localparam logic [4:0] KIND_RIGHT_DOWN = 5'd8;
   localparam logic [4:0] KIND_FOCUS_NEAR = 5'd12;
   localparam logic [4:0] KIND_FOCUS_FAR  = 5'd13;
   localparam logic [4:0] KIND_IRIS_OPEN  = 5'd15;
   localparam logic [4:0] KIND_IRIS_CLOSE = 5'd16;
   localparam logic [4:0] KIND_ZOOM_IN    = 5'd18;
   localparam logic [4:0] KIND_ZOOM_OUT   = 5'd19;
   localparam logic [4:0] KIND_PRESET_1   = 5'd21;
   localparam logic [4:0] KIND_PRESET_9   = 5'd29;
   localparam logic [4:0] KIND_HOME       = 5'd30;
   localparam logic [7:0] PRESET_BASE     = 8'd20;

   // Config subcodes, compared against the whole command value.
   localparam logic [31:0] CFG_ON       = 32'd0;
   localparam logic [31:0] CFG_OFF      = 32'd1;
   localparam logic [31:0] CFG_UP       = 32'd2;
   localparam logic [31:0] CFG_DOWN     = 32'd3;
   localparam logic [31:0] CFG_LEFT     = 32'd4;
   localparam logic [31:0] CFG_RIGHT    = 32'd5;
   localparam logic [31:0] CFG_SET1     = 32'd6;
   localparam logic [31:0] CFG_SET2     = 32'd7;
   localparam logic [31:0] CFG_ZOOM_IN  = 32'd10;
   localparam logic [31:0] CFG_ZOOM_OUT = 32'd11;
   localparam logic [31:0] PRESET_MODE1 = 32'd1;
   localparam logic [31:0] PRESET_MODE2 = 32'd2;

   // Repeat policies and follow-up stops.
   localparam logic [1:0] POL_DEFAULT = 2'd0;
   localparam logic [1:0] POL_ONCE    = 2'd1;
   localparam logic [1:0] POL_THREE   = 2'd2;
   localparam logic [1:0] POL_FOREVER = 2'd3;
   localparam logic [1:0] FUP_NONE    = 2'd0;
   localparam logic [1:0] FUP_TILT    = 2'd1;
   localparam logic [1:0] FUP_PAN     = 2'd2;
   localparam logic [1:0] FUP_ZOOM    = 2'd3;

   localparam logic [3:0] SPEED_MAX   = 4'd10;
   localparam logic [2:0] SPEED_FIXED = 3'd7;

   // One classified command, as held in the queue.
   typedef struct packed {
      logic [6:0] camera_id;
      logic [7:0] function_byte;
      logic [7:0] lens_byte;
      logic [7:0] motion_byte;
      logic [7:0] checksum;
      logic [1:0] repeat_policy;
      logic [1:0] follow_up_stop;
   } ptzenc_frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ptzenc_q_status_type;

   // Speed 0..10 mapped to round(0.7 * s).
   function automatic logic [2:0] speed_code(input logic [3:0] s);
      logic [2:0] code;
      case (s)
         4'd0:    code = 3'd0;
         4'd1:    code = 3'd1;
         4'd2:    code = 3'd1;
         4'd3:    code = 3'd2;
         4'd4:    code = 3'd3;
         4'd5:    code = 3'd4;
         4'd6:    code = 3'd4;
         4'd7:    code = 3'd5;
         4'd8:    code = 3'd6;
         4'd9:    code = 3'd6;
         default: code = 3'd7;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/ptzenc_front.sv
module ptzenc_front
   import ptzenc_pkg::*;
(
   input  logic [6:0]       req_camera_id,
   input  logic [4:0]       req_command_kind,
   input  logic [31:0]      req_command_value,
   output ptzenc_frame_type frame
);

   logic [3:0] px;
   logic [3:0] py;
   logic [2:0] sx;
   logic [2:0] sy;
   logic [4:0] kind;
   logic [7:0] fn;
   logic [7:0] lens;
   logic [7:0] mot;
   logic [1:0] pol;
   logic [1:0] fup;
   logic [1:0] dirpol;
   logic [1:0] zoompol;
   logic [7:0] sum;

   always_comb begin
      px = (req_command_value[15:0] > 16'(SPEED_MAX)) ? SPEED_MAX : req_command_value[3:0];
      py = (req_command_value[31:16] > 16'(SPEED_MAX)) ? SPEED_MAX : req_command_value[19:16];
      if (py == 4'd0) begin
         py = px;
      end
      sx      = speed_code(px);
      sy      = speed_code(py);
      kind    = req_command_kind;
      fn      = FN_DEFAULT;
      lens    = LENS_DEFAULT;
      mot     = MOT_DEFAULT;
      pol     = POL_DEFAULT;
      fup     = FUP_NONE;
      dirpol  = POL_FOREVER;
      zoompol = POL_FOREVER;

      // Config subcodes either set the bytes outright or stand in for a
      // direction or zoom command at a fixed speed.
      if (req_command_kind == KIND_CONFIG) begin
         unique case (req_command_value)
            CFG_ON: begin
               fn = FN_CFG_ON; lens = BYTE_FIXED; mot = BYTE_FIXED;
            end
            CFG_OFF: begin
               fn = FN_CFG_OFF; lens = BYTE_FIXED; mot = BYTE_FIXED; pol = POL_THREE;
            end
            CFG_UP: begin
               kind = KIND_TILT_UP; sx = SPEED_FIXED; dirpol = POL_ONCE; fup = FUP_TILT;
            end
            CFG_DOWN: begin
               kind = KIND_TILT_DOWN; sx = SPEED_FIXED; dirpol = POL_ONCE; fup = FUP_TILT;
            end
            CFG_LEFT: begin
               kind = KIND_PAN_LEFT; sx = SPEED_FIXED; dirpol = POL_ONCE; fup = FUP_PAN;
            end
            CFG_RIGHT: begin
               kind = KIND_PAN_RIGHT; sx = SPEED_FIXED; dirpol = POL_ONCE; fup = FUP_PAN;
            end
            CFG_SET1: begin
               fn = FN_CFG_SET1; lens = BYTE_FIXED; mot = MOT_CFG_SET1;
            end
            CFG_SET2: begin
               fn = FN_CFG_OFF; lens = BYTE_FIXED; mot = BYTE_FIXED;
            end
            CFG_ZOOM_IN: begin
               kind = KIND_ZOOM_IN; zoompol = POL_ONCE; fup = FUP_ZOOM;
            end
            CFG_ZOOM_OUT: begin
               kind = KIND_ZOOM_OUT; zoompol = POL_ONCE; fup = FUP_ZOOM;
            end
            default: begin
            end
         endcase
      end

      unique case (kind) inside
         KIND_PAN_LEFT: begin
            mot = MOT_DEFAULT - {1'b0, sx, 4'b0000}; pol = dirpol;
         end
         KIND_PAN_RIGHT: begin
            mot = MOT_DEFAULT + {1'b0, sx, 4'b0000}; pol = dirpol;
         end
         KIND_TILT_UP: begin
            mot = MOT_DEFAULT + {5'b00000, sx}; pol = dirpol;
         end
         KIND_TILT_DOWN: begin
            mot = MOT_DEFAULT - {5'b00000, sx}; pol = dirpol;
         end
         KIND_LEFT_UP: begin
            mot = (MOT_CENTRE_HIGH - {1'b0, sx, 4'b0000}) | (MOT_CENTRE_LOW + {5'b00000, sy});
            pol = POL_FOREVER;
         end
         KIND_LEFT_DOWN: begin
            mot = (MOT_CENTRE_HIGH - {1'b0, sx, 4'b0000}) | (MOT_CENTRE_LOW - {5'b00000, sy});
            pol = POL_FOREVER;
         end
         KIND_RIGHT_UP: begin
            mot = (MOT_CENTRE_HIGH + {1'b0, sx, 4'b0000}) | (MOT_CENTRE_LOW + {5'b00000, sy});
            pol = POL_FOREVER;
         end
         KIND_RIGHT_DOWN: begin
            mot = (MOT_CENTRE_HIGH + {1'b0, sx, 4'b0000}) | (MOT_CENTRE_LOW - {5'b00000, sy});
            pol = POL_FOREVER;
         end
         KIND_FOCUS_NEAR: begin
            lens = LENS_FOCUS_NEAR; pol = POL_FOREVER;
         end
         KIND_FOCUS_FAR: begin
            lens = LENS_FOCUS_FAR; pol = POL_FOREVER;
         end
         KIND_IRIS_OPEN: begin
            lens = LENS_IRIS_OPEN; pol = POL_FOREVER;
         end
         KIND_IRIS_CLOSE: begin
            lens = LENS_IRIS_CLOSE; pol = POL_FOREVER;
         end
         KIND_ZOOM_IN: begin
            lens = LENS_ZOOM_IN; pol = zoompol;
         end
         KIND_ZOOM_OUT: begin
            lens = LENS_ZOOM_OUT; pol = zoompol;
         end
         [KIND_PRESET_1:KIND_PRESET_9]: begin
            if (req_command_value == PRESET_MODE2) begin
               fn = FN_PRESET_MODE2;
            end else if (req_command_value == PRESET_MODE1) begin
               fn = FN_PRESET_MODE1;
            end else begin
               fn = FN_PRESET_GO;
            end
            lens = BYTE_FIXED;
            mot  = BYTE_FIXED + {3'b000, kind} - PRESET_BASE;
         end
         KIND_HOME: begin
            if (req_command_value == 32'd0) begin
               fn = FN_HOME; lens = BYTE_FIXED; mot = BYTE_FIXED;
            end
         end
         default: begin
         end
      endcase

      sum = BYTE_SYNC + {1'b0, req_camera_id} + fn + lens + mot + BYTE_END;

      frame.camera_id      = req_camera_id;
      frame.function_byte  = fn;
      frame.lens_byte      = lens;
      frame.motion_byte    = mot;
      frame.checksum       = sum;
      frame.repeat_policy  = pol;
      frame.follow_up_stop = fup;
   end

endmodule

FILE: rtl/ptzenc_queue.sv
module ptzenc_queue
   import ptzenc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ptzenc_frame_type    push_frame,
   input  logic                pop,
   output ptzenc_frame_type    head_frame,
   output ptzenc_q_status_type status
);

   ptzenc_frame_type slot_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
      head_frame   = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/ptzenc_back.sv
module ptzenc_back
   import ptzenc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ptzenc_frame_type    head_frame,
   input  ptzenc_q_status_type q_status,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_frame_last,
   output logic [1:0]          rsp_repeat_policy,
   output logic [1:0]          rsp_follow_up_stop
);

   ptzenc_frame_type cur_ff;
   ptzenc_frame_type cur_in;
   logic             loaded_ff;
   logic             loaded_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             valid_ff;
   logic             valid_in;
   logic [7:0]       byte_ff;
   logic [7:0]       byte_in;
   logic             last_ff;
   logic             last_in;
   logic [1:0]       pol_ff;
   logic [1:0]       pol_in;
   logic [1:0]       fup_ff;
   logic [1:0]       fup_in;
   logic             advance;
   logic             done;
   logic [7:0]       sel_byte;

   always_comb begin
      case (idx_ff)
         POS_SYNC:     sel_byte = BYTE_SYNC;
         POS_ID:       sel_byte = {1'b0, cur_ff.camera_id};
         POS_FUNCTION: sel_byte = cur_ff.function_byte;
         POS_LENS:     sel_byte = cur_ff.lens_byte;
         POS_MOTION:   sel_byte = cur_ff.motion_byte;
         POS_END:      sel_byte = BYTE_END;
         default:      sel_byte = cur_ff.checksum;
      endcase

      advance   = !valid_ff || !rsp_stall;
      done      = advance && loaded_ff && (idx_ff == IDX_LAST);
      cur_in    = cur_ff;
      loaded_in = loaded_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      pol_in    = pol_ff;
      fup_in    = fup_ff;

      if (advance) begin
         valid_in = loaded_ff;
         if (loaded_ff) begin
            byte_in = sel_byte;
            last_in = (idx_ff == IDX_LAST);
            pol_in  = cur_ff.repeat_policy;
            fup_in  = cur_ff.follow_up_stop;
            if (idx_ff == IDX_LAST) begin
               loaded_in = 1'b0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end

      pop = (!loaded_ff || done) && !q_status.empty;
      if (pop) begin
         cur_in    = head_frame;
         loaded_in = 1'b1;
         idx_in    = POS_SYNC;
      end

      rsp_valid          = valid_ff;
      rsp_frame_byte     = byte_ff;
      rsp_frame_last     = last_ff;
      rsp_repeat_policy  = pol_ff;
      rsp_follow_up_stop = fup_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      pol_ff  <= pol_in;
      fup_ff  <= fup_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         idx_ff    <= POS_SYNC;
         valid_ff  <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

FILE: rtl/ptz_command_frame_encoder_core.sv
// The first byte of a frame passes through the queue, the back end's frame register and its
// output register. The byte serialiser sends one frame byte per cycle while rsp_stall is low;
// a two-entry queue lets new requests in while a frame is sent.
// Reset is synchronous and active high; it empties the queue and drops rsp_valid.
// The seventh byte of every frame carries the checksum and the last flag.
module ptz_command_frame_encoder_core
   import ptzenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [6:0]  req_camera_id,
   input  logic [4:0]  req_command_kind,
   input  logic [31:0] req_command_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_last,
   output logic [1:0]  rsp_repeat_policy,
   output logic [1:0]  rsp_follow_up_stop
);

   // The front end decodes a request into the function, lens and motion bytes,
   // the checksum and the policy tags, all in the cycle the request arrives.
   ptzenc_frame_type    new_frame;
   ptzenc_frame_type    head_frame;
   ptzenc_q_status_type q_status;
   logic                push;
   logic                pop;

   ptzenc_front u_front (
      .req_camera_id     (req_camera_id),
      .req_command_kind  (req_command_kind),
      .req_command_value (req_command_value),
      .frame             (new_frame)
   );

   // A request is taken whenever the queue has room, so the front end does
   // not wait for the serialiser to finish the previous frame.
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   ptzenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (new_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .status     (q_status)
   );

   // The back end holds one frame and walks through its seven bytes into a
   // registered output; the next frame is loaded as the last byte leaves,
   // so consecutive frames follow without a gap.
   ptzenc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_frame         (head_frame),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_repeat_policy  (rsp_repeat_policy),
      .rsp_follow_up_stop (rsp_follow_up_stop)
   );

endmodule

FILE: rtl/ptzenc_checker.sv
module ptzenc_checker
   import ptzenc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_frame_last,
   input logic [1:0] rsp_repeat_policy,
   input logic [1:0] rsp_follow_up_stop
);

   logic [IDX_W-1:0] pos_ff;
   logic [IDX_W-1:0] pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && !rsp_stall) begin
         pos_in = (pos_ff == IDX_LAST) ? POS_SYNC : pos_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_SYNC;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_repeat_policy) && $stable(rsp_follow_up_stop))
      else $error("stalled response changed");

   a_sync_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pos_ff == POS_SYNC) |-> rsp_frame_byte == BYTE_SYNC)
      else $error("frame does not open with the sync byte");

   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pos_ff == POS_END) |-> rsp_frame_byte == BYTE_END)
      else $error("sixth frame byte is not the end marker");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_last == (pos_ff == IDX_LAST))
      else $error("last flag not on the seventh byte");

endmodule

bind ptz_command_frame_encoder_core ptzenc_checker u_ptzenc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_frame_byte     (rsp_frame_byte),
   .rsp_frame_last     (rsp_frame_last),
   .rsp_repeat_policy  (rsp_repeat_policy),
   .rsp_follow_up_stop (rsp_follow_up_stop)
);
